>>> rtl/core/sme_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine executor package
// Shared constants, opcodes, status codes and word types of the executor.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int unsigned DEF_WORD_BITS      = 32;
	localparam int unsigned DEF_STACK_DEPTH    = 256;
	localparam int unsigned DEF_MAX_PRINT_ARGS = 64;

	localparam logic [7:0] OP_PUSH   = 8'd0;
	localparam logic [7:0] OP_ADD    = 8'd1;
	localparam logic [7:0] OP_SUB    = 8'd2;
	localparam logic [7:0] OP_MUL    = 8'd3;
	localparam logic [7:0] OP_DIV    = 8'd4;
	localparam logic [7:0] OP_SHL    = 8'd5;
	localparam logic [7:0] OP_SHR    = 8'd6;
	localparam logic [7:0] OP_EMIT   = 8'd7;
	localparam logic [7:0] OP_EXIT   = 8'd8;

	localparam logic [2:0] ST_VALUE    = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_RETURNED = 3'd2;
	localparam logic [2:0] ST_BADOP    = 3'd3;
	localparam logic [2:0] ST_UNDER    = 3'd4;
	localparam logic [2:0] ST_OVER     = 3'd5;
	localparam logic [2:0] ST_COUNT    = 3'd6;
	localparam logic [2:0] ST_DIVZERO  = 3'd7;

	typedef struct packed {
		logic [7:0]  mode;
		logic [31:0] immediate;
		logic [7:0]  arg_count;
	} instr_t;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  status;
		logic        last;
	} result_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_SHL,
		ALU_SHR
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctrl_t;

endpackage

>>> rtl/core/sme_alu.sv
// ----------------------------------------------------------------------------
// Stack machine executor arithmetic unit
// Shared unit: registered add, subtract and shifts, bit-serial multiply and
// restoring divide that take one step per cycle.
// ----------------------------------------------------------------------------
module sme_alu #(
	parameter int unsigned WORD_BITS = sme_pkg::DEF_WORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sme_pkg::alu_ctrl_t    ctrl,
	input  logic [WORD_BITS-1:0]  lhs,
	input  logic [WORD_BITS-1:0]  rhs,
	output logic                  done,
	output logic [WORD_BITS-1:0]  result
);

	localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);
	localparam int unsigned SH_W  = $clog2(WORD_BITS);

	logic                 busy_q;
	logic                 done_q;
	sme_pkg::alu_op_t     op_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS:0]   diff;
	logic                 fits;
	logic                 shift_over;
	logic [WORD_BITS-1:0] quick;

	always_comb begin
		trial      = {acc_q, a_q[WORD_BITS-1]};
		diff       = trial - {1'b0, b_q};
		fits       = trial >= {1'b0, b_q};
		shift_over = rhs >= WORD_BITS'(WORD_BITS);
		unique case (ctrl.op)
			sme_pkg::ALU_ADD: quick = lhs + rhs;
			sme_pkg::ALU_SUB: quick = lhs - rhs;
			sme_pkg::ALU_SHL: quick = shift_over ? '0 : (lhs << rhs[SH_W-1:0]);
			sme_pkg::ALU_SHR: quick = shift_over ? '0 : (lhs >> rhs[SH_W-1:0]);
			default:          quick = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= sme_pkg::ALU_ADD;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				op_q <= ctrl.op;
				if (ctrl.op == sme_pkg::ALU_MUL || ctrl.op == sme_pkg::ALU_DIV) begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(WORD_BITS);
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q <= lhs;
			b_q <= rhs;
			if (ctrl.op == sme_pkg::ALU_MUL || ctrl.op == sme_pkg::ALU_DIV) begin
				acc_q <= '0;
			end else begin
				acc_q <= quick;
			end
		end else if (busy_q) begin
			case (op_q)
				sme_pkg::ALU_MUL: begin
					if (b_q[0]) begin
						acc_q <= acc_q + a_q;
					end
					a_q <= a_q << 1;
					b_q <= b_q >> 1;
				end
				sme_pkg::ALU_DIV: begin
					if (fits) begin
						acc_q <= diff[WORD_BITS-1:0];
					end else begin
						acc_q <= trial[WORD_BITS-1:0];
					end
					a_q <= {a_q[WORD_BITS-2:0], fits};
				end
				default: begin
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = (op_q == sme_pkg::ALU_DIV) ? a_q : acc_q;

endmodule

>>> rtl/core/stack_machine_executor_unit.sv
// ----------------------------------------------------------------------------
// Stack machine executor
// Runs one stack-machine instruction per input word against an operand stack.
// ----------------------------------------------------------------------------
// The instr channel carries one instruction per word; the result channel
// returns the words an instruction produces (printed values or one status).
// Both channels use valid/stall; a word moves when valid is high and stall low.
// The block takes one instruction at a time and stalls instr until it is done.
// A push writes the stack as it is taken. Add, subtract and shifts use two stack
// reads through the single registered memory read port and then the shared unit.
// Multiply and divide run through the one-bit-per-cycle steps of the shared
// unit. Print sends its values from the stack in order, and a status goes out
// from the status state, each result needing a free output register.
// Results pass through an output register, so a new instruction is taken
// while the last result still waits. When the receiver stalls, print and
// status results wait in place. After a return or an error the block halts:
// it keeps taking instructions and drops them until reset. Reset empties the
// stack and clears the halt; the stack memory itself needs no clearing.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit #(
	parameter int unsigned WORD_BITS      = sme_pkg::DEF_WORD_BITS,
	parameter int unsigned STACK_DEPTH    = sme_pkg::DEF_STACK_DEPTH,
	parameter int unsigned MAX_PRINT_ARGS = sme_pkg::DEF_MAX_PRINT_ARGS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sme_pkg::instr_t  instr,
	input  logic             instr_valid,
	output logic             instr_stall,
	output sme_pkg::result_t result,
	output logic             result_valid,
	input  logic             result_stall
);

	localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
	localparam int unsigned DEP_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned CNT_W = $clog2(MAX_PRINT_ARGS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_L,
		S_EXEC,
		S_WAIT,
		S_PR_OUT,
		S_STATUS
	} state_t;

	state_t               state_q;
	logic [DEP_W-1:0]     depth_q;
	logic                 halted_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     rem_q;
	logic [2:0]           status_q;
	sme_pkg::alu_op_t     alu_op_q;
	logic [WORD_BITS-1:0] r_q;
	sme_pkg::result_t     result_q;
	logic                 result_valid_q;

	logic [WORD_BITS-1:0] mem [STACK_DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 wr_en;

	logic                 accept;
	logic                 out_free;
	logic [IDX_W-1:0]     idx_top;
	logic [IDX_W-1:0]     idx_sub;
	logic [IDX_W-1:0]     print_base;
	logic [63:0]          imm_ext;
	logic [63:0]          rd_ext;
	logic                 depth_full;
	logic                 count_big;
	logic                 count_deep;
	logic                 div_zero;

	sme_pkg::alu_ctrl_t   alu_ctrl;
	logic                 alu_done;
	logic [WORD_BITS-1:0] alu_result;

	assign accept     = instr_valid && (state_q == S_IDLE);
	assign out_free   = !result_valid_q || !result_stall;
	assign idx_top    = IDX_W'(depth_q - 1'b1);
	assign idx_sub    = IDX_W'(depth_q - 2'd2);
	assign print_base = IDX_W'(depth_q - DEP_W'(instr.arg_count));
	assign imm_ext    = 64'(instr.immediate);
	assign rd_ext     = 64'(rdata_q);
	assign depth_full = depth_q == DEP_W'(STACK_DEPTH);
	assign count_big  = instr.arg_count > 8'(MAX_PRINT_ARGS);
	assign count_deep = 16'(instr.arg_count) > 16'(depth_q);
	assign div_zero   = (alu_op_q == sme_pkg::ALU_DIV) && (r_q == '0);

	assign alu_ctrl.start = (state_q == S_EXEC) && !div_zero;
	assign alu_ctrl.op    = alu_op_q;

	sme_alu #(
		.WORD_BITS(WORD_BITS)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (alu_ctrl),
		.lhs   (rdata_q),
		.rhs   (r_q),
		.done  (alu_done),
		.result(alu_result)
	);

	always_comb begin
		unique case (state_q)
			S_IDLE:   rd_addr = (instr.mode == sme_pkg::OP_EMIT) ? print_base : idx_top;
			S_PR_OUT: rd_addr = out_free ? IDX_W'(ptr_q + 1'b1) : ptr_q;
			default:  rd_addr = idx_sub;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = IDX_W'(depth_q);
		wr_data = imm_ext[WORD_BITS-1:0];
		if (accept && !halted_q && instr.mode == sme_pkg::OP_PUSH && !depth_full) begin
			wr_en = 1'b1;
		end else if (state_q == S_WAIT && alu_done) begin
			wr_en   = 1'b1;
			wr_addr = idx_sub;
			wr_data = alu_result;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			depth_q        <= '0;
			halted_q       <= 1'b0;
			ptr_q          <= '0;
			rem_q          <= '0;
			status_q       <= sme_pkg::ST_VALUE;
			alu_op_q       <= sme_pkg::ALU_ADD;
			r_q            <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && !halted_q) begin
						unique case (instr.mode) inside
							sme_pkg::OP_PUSH: begin
								if (depth_full) begin
									status_q <= sme_pkg::ST_OVER;
									halted_q <= 1'b1;
									state_q  <= S_STATUS;
								end else begin
									depth_q <= DEP_W'(depth_q + 1'b1);
								end
							end
							[sme_pkg::OP_ADD:sme_pkg::OP_SHR]: begin
								if (depth_q < DEP_W'(2)) begin
									status_q <= sme_pkg::ST_UNDER;
									halted_q <= 1'b1;
									state_q  <= S_STATUS;
								end else begin
									case (instr.mode)
										sme_pkg::OP_ADD: alu_op_q <= sme_pkg::ALU_ADD;
										sme_pkg::OP_SUB: alu_op_q <= sme_pkg::ALU_SUB;
										sme_pkg::OP_MUL: alu_op_q <= sme_pkg::ALU_MUL;
										sme_pkg::OP_DIV: alu_op_q <= sme_pkg::ALU_DIV;
										sme_pkg::OP_SHL: alu_op_q <= sme_pkg::ALU_SHL;
										default:         alu_op_q <= sme_pkg::ALU_SHR;
									endcase
									state_q <= S_RD_L;
								end
							end
							sme_pkg::OP_EMIT: begin
								if (count_big) begin
									status_q <= sme_pkg::ST_COUNT;
									halted_q <= 1'b1;
									state_q  <= S_STATUS;
								end else if (count_deep) begin
									status_q <= sme_pkg::ST_UNDER;
									halted_q <= 1'b1;
									state_q  <= S_STATUS;
								end else if (instr.arg_count == '0) begin
									status_q <= sme_pkg::ST_EMPTY;
									state_q  <= S_STATUS;
								end else begin
									depth_q <= DEP_W'(depth_q - DEP_W'(instr.arg_count));
									ptr_q   <= print_base;
									rem_q   <= CNT_W'(instr.arg_count);
									state_q <= S_PR_OUT;
								end
							end
							sme_pkg::OP_EXIT: begin
								status_q <= sme_pkg::ST_RETURNED;
								halted_q <= 1'b1;
								state_q  <= S_STATUS;
							end
							default: begin
								status_q <= sme_pkg::ST_BADOP;
								halted_q <= 1'b1;
								state_q  <= S_STATUS;
							end
						endcase
					end
				end
				S_RD_L: begin
					r_q     <= rdata_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (div_zero) begin
						status_q <= sme_pkg::ST_DIVZERO;
						halted_q <= 1'b1;
						state_q  <= S_STATUS;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (alu_done) begin
						depth_q <= DEP_W'(depth_q - 1'b1);
						state_q <= S_IDLE;
					end
				end
				S_PR_OUT: begin
					if (out_free) begin
						result_q.value  <= rd_ext[31:0];
						result_q.status <= sme_pkg::ST_VALUE;
						result_q.last   <= rem_q == CNT_W'(1);
						result_valid_q  <= 1'b1;
						if (rem_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= IDX_W'(ptr_q + 1'b1);
							rem_q <= CNT_W'(rem_q - 1'b1);
						end
					end
				end
				S_STATUS: begin
					if (out_free) begin
						result_q.value  <= '0;
						result_q.status <= status_q;
						result_q.last   <= 1'b1;
						result_valid_q  <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign instr_stall  = state_q != S_IDLE;
	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Stack machine executor testbench
// Drives instruction words into the executor and checks every result word
// against an in-bench model of the operand stack. A short directed program
// is followed by random, well-formed programs under three idling patterns.
// The run ends with one randomly chosen halting instruction, after any words
// that set it up, and eight words that the halted block must drop.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] BINARY_OPS [6] = '{
		sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
		sme_pkg::OP_DIV, sme_pkg::OP_SHL, sme_pkg::OP_SHR
	};

	class stack_predictor;
		logic [31:0] words [sme_pkg::DEF_STACK_DEPTH];
		int unsigned depth;
		bit halted;
		sme_pkg::result_t pending [$];
		int unsigned mismatches;

		function void emit(logic [31:0] value, logic [2:0] status, logic last);
			sme_pkg::result_t r;
			r.value = value;
			r.status = status;
			r.last = last;
			pending.push_back(r);
		endfunction

		function void halt(logic [2:0] status);
			halted = 1'b1;
			emit(32'd0, status, 1'b1);
		endfunction

		function void execute(sme_pkg::instr_t w);
			logic [31:0] lhs;
			logic [31:0] rhs;
			logic [31:0] res;
			int unsigned n;
			int unsigned i;
			if (halted)
				return;
			case (w.mode)
				sme_pkg::OP_PUSH: begin
					if (depth >= sme_pkg::DEF_STACK_DEPTH) begin
						halt(sme_pkg::ST_OVER);
					end else begin
						words[depth] = w.immediate;
						depth++;
					end
				end
				sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
				sme_pkg::OP_DIV, sme_pkg::OP_SHL, sme_pkg::OP_SHR: begin
					if (depth < 2) begin
						halt(sme_pkg::ST_UNDER);
						return;
					end
					rhs = words[depth - 1];
					lhs = words[depth - 2];
					if (w.mode == sme_pkg::OP_DIV && rhs == 32'd0) begin
						halt(sme_pkg::ST_DIVZERO);
						return;
					end
					case (w.mode)
						sme_pkg::OP_ADD: res = lhs + rhs;
						sme_pkg::OP_SUB: res = lhs - rhs;
						sme_pkg::OP_MUL: res = lhs * rhs;
						sme_pkg::OP_DIV: res = lhs / rhs;
						sme_pkg::OP_SHL:
							res = (rhs >= sme_pkg::DEF_WORD_BITS) ? 32'd0 : lhs << rhs;
						default:
							res = (rhs >= sme_pkg::DEF_WORD_BITS) ? 32'd0 : lhs >> rhs;
					endcase
					depth--;
					words[depth - 1] = res;
				end
				sme_pkg::OP_EMIT: begin
					n = w.arg_count;
					if (n > sme_pkg::DEF_MAX_PRINT_ARGS) begin
						halt(sme_pkg::ST_COUNT);
					end else if (n > depth) begin
						halt(sme_pkg::ST_UNDER);
					end else if (n == 0) begin
						emit(32'd0, sme_pkg::ST_EMPTY, 1'b1);
					end else begin
						for (i = 0; i < n; i++)
							emit(words[depth - n + i], sme_pkg::ST_VALUE, i == n - 1);
						depth -= n;
					end
				end
				sme_pkg::OP_EXIT: halt(sme_pkg::ST_RETURNED);
				default: halt(sme_pkg::ST_BADOP);
			endcase
		endfunction

		function void compare_output(sme_pkg::result_t got);
			sme_pkg::result_t want;
			if (pending.size() == 0) begin
				$error("unexpected result word: value %08h status %0d last %0b",
					got.value, got.status, got.last);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (got.value !== want.value) begin
				$error("value: expected %08h, got %08h", want.value, got.value);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	sme_pkg::instr_t instr = '0;
	logic instr_valid = 1'b0;
	logic instr_stall;
	sme_pkg::result_t result;
	logic result_valid;
	logic result_stall = 1'b0;

	int unsigned tx_idle_pct = 14;
	int unsigned rx_stall_pct = 67;
	stack_predictor machine = new();

	stack_machine_executor_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr        (instr),
		.instr_valid  (instr_valid),
		.instr_stall  (instr_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			machine.compare_output(result);
	end

	function automatic sme_pkg::instr_t op_of(logic [7:0] code);
		sme_pkg::instr_t w;
		w.mode = code;
		w.immediate = $urandom;
		w.arg_count = 8'($urandom_range(255));
		return w;
	endfunction

	function automatic sme_pkg::instr_t push_of(logic [31:0] imm);
		sme_pkg::instr_t w;
		w = op_of(sme_pkg::OP_PUSH);
		w.immediate = imm;
		return w;
	endfunction

	function automatic sme_pkg::instr_t print_of(int unsigned n);
		sme_pkg::instr_t w;
		w = op_of(sme_pkg::OP_EMIT);
		w.arg_count = 8'(n);
		return w;
	endfunction

	function automatic logic [31:0] pick_immediate();
		logic [31:0] corners [4] = '{32'd0, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF};
		case ($urandom_range(3))
			0, 1: return $urandom;
			2: return $urandom_range(40);
			default: return corners[$urandom_range(3)];
		endcase
	endfunction

	function automatic int unsigned print_cap();
		return (machine.depth < sme_pkg::DEF_MAX_PRINT_ARGS) ?
			machine.depth : sme_pkg::DEF_MAX_PRINT_ARGS;
	endfunction

	task automatic issue(sme_pkg::instr_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			instr_valid <= 1'b0;
			@(posedge clk);
		end
		instr <= w;
		instr_valid <= 1'b1;
		do @(posedge clk); while (instr_stall);
		machine.execute(w);
	endtask

	task automatic wait_for_results();
		instr_valid <= 1'b0;
		do @(posedge clk); while (machine.pending.size() != 0);
	endtask

	task automatic run_directed();
		issue(print_of(0));
		issue(push_of(32'hFFFF_FFFF));
		issue(push_of(32'hFFFF_FFFF));
		issue(op_of(sme_pkg::OP_ADD));
		issue(push_of(32'hFFFF_FFFF));
		issue(op_of(sme_pkg::OP_SUB));
		issue(push_of(32'd7));
		issue(op_of(sme_pkg::OP_DIV));
		issue(push_of(32'd31));
		issue(op_of(sme_pkg::OP_SHL));
		issue(push_of(32'd32));
		issue(op_of(sme_pkg::OP_SHR));
		issue(push_of(32'hDEAD_BEEF));
		issue(push_of(32'd31));
		issue(op_of(sme_pkg::OP_SHR));
		issue(op_of(sme_pkg::OP_MUL));
		issue(push_of(32'h1234_5678));
		issue(push_of(32'd200));
		issue(op_of(sme_pkg::OP_SHL));
		issue(push_of(32'h0000_FFFF));
		issue(push_of(32'd0));
		issue(print_of(3));
		issue(print_of(1));
	endtask

	task automatic run_random(int unsigned items);
		repeat (items) begin
			int unsigned roll;
			logic [7:0] code;
			roll = $urandom_range(99);
			if (machine.depth < 2 || roll < 45) begin
				issue(push_of(pick_immediate()));
			end else if (roll < 85) begin
				code = BINARY_OPS[$urandom_range(5)];
				if (code == sme_pkg::OP_DIV && machine.words[machine.depth - 1] == 32'd0)
					code = sme_pkg::OP_SUB;
				issue(op_of(code));
			end else if ($urandom_range(3) == 0) begin
				issue(print_of(print_cap()));
			end else begin
				issue(print_of($urandom_range(print_cap())));
			end
		end
	endtask

	task automatic run_halting_end();
		case ($urandom_range(6))
			0: issue(op_of(sme_pkg::OP_EXIT));
			1: issue(op_of(8'($urandom_range(sme_pkg::OP_EXIT + 1, 255))));
			2: begin
				while (machine.depth >= 2)
					issue(print_of(print_cap()));
				issue(op_of(BINARY_OPS[$urandom_range(5)]));
			end
			3: begin
				while (machine.depth >= sme_pkg::DEF_MAX_PRINT_ARGS)
					issue(print_of(sme_pkg::DEF_MAX_PRINT_ARGS));
				issue(print_of($urandom_range(machine.depth + 1,
					sme_pkg::DEF_MAX_PRINT_ARGS)));
			end
			4: issue(print_of($urandom_range(sme_pkg::DEF_MAX_PRINT_ARGS + 1, 255)));
			5: begin
				issue(push_of($urandom));
				issue(push_of(32'd0));
				issue(op_of(sme_pkg::OP_DIV));
			end
			default: begin
				while (machine.depth < sme_pkg::DEF_STACK_DEPTH)
					issue(push_of($urandom));
				issue(push_of($urandom));
			end
		endcase
		repeat (8)
			issue(op_of(8'($urandom_range(255))));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_random(100);
		while (machine.depth < sme_pkg::DEF_MAX_PRINT_ARGS)
			issue(push_of($urandom));
		issue(print_of(sme_pkg::DEF_MAX_PRINT_ARGS));
		wait_for_results();

		tx_idle_pct = 67;
		rx_stall_pct = 14;
		run_random(100);
		wait_for_results();

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		run_random(100);
		run_halting_end();

		wait_for_results();
		repeat (100) @(posedge clk);
		if (machine.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

>>> stack_machine_executor_unit.f
rtl/core/sme_pkg.sv
rtl/core/sme_alu.sv
rtl/core/stack_machine_executor_unit.sv
verif/testbench.sv
